[hw/rtl/vector_clock_unit_macros.svh]
// assertion macros for the vector clock unit checker
// no dependencies; included by the checker file
`ifndef VECTOR_CLOCK_UNIT_MACROS_SVH
`define VECTOR_CLOCK_UNIT_MACROS_SVH

// same-cycle implication under reset
`define VCU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define VCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vcu_pkg.sv]
// shared types, widths and command codes for the vector clock unit
// no dependencies
package vcu_pkg;

    localparam int LANES       = 8;
    localparam int THREADS_DEF = 8;
    localparam int VAL_W       = 31;
    localparam int CMD_W       = 3;
    localparam int IDX_W       = 3;

    localparam int CMD_LSB  = 0;
    localparam int IDX_LSB  = CMD_LSB + CMD_W;
    localparam int VAL_LSB  = IDX_LSB + IDX_W;
    localparam int OPND_LSB = VAL_LSB + VAL_W;
    localparam int S_DATA_W = ((OPND_LSB + LANES * VAL_W + 7) / 8) * 8;

    localparam int FLAG_LSB = LANES * VAL_W;
    localparam int FLAG_W   = 4;
    localparam int M_DATA_W = ((FLAG_LSB + FLAG_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_JOIN    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MEET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    typedef struct packed {
        logic gt;
        logic lt;
        logic nz;
    } lane_flags_t;

    typedef struct packed {
        logic meets_below;
        logic lex_less;
        logic above_or_equal;
        logic below_or_equal;
    } relation_t;

endpackage

[hw/rtl/vcu_lane.sv]
// one lane: compares a stored entry with the operand entry and forms its next value
// depends on vcu_pkg
module vcu_lane
    import vcu_pkg::*;
(
    input  logic [CMD_W-1:0] cmd,
    input  logic             set_hit,
    input  logic [VAL_W-1:0] entry_value,
    input  logic [VAL_W-1:0] own,
    input  logic [VAL_W-1:0] opnd,
    output logic [VAL_W-1:0] next_value,
    output lane_flags_t      flags
);

    logic gt;
    logic lt;

    assign gt = own > opnd;
    assign lt = own < opnd;

    assign flags.gt = gt;
    assign flags.lt = lt;
    assign flags.nz = |opnd;

    always_comb
    begin
        unique case (cmd)
            CMD_LOAD: next_value = opnd;
            CMD_JOIN: next_value = lt ? opnd : own;
            CMD_MEET: next_value = gt ? opnd : own;
            CMD_SET:  next_value = set_hit ? entry_value : own;
            default:  next_value = own;
        endcase
    end

endmodule

[hw/rtl/vcu_merge.sv]
// merges per-lane compare results into the four relation flags
// depends on vcu_pkg
module vcu_merge
    import vcu_pkg::*;
(
    input  lane_flags_t flags [LANES],
    output relation_t   rel
);

    always_comb
    begin
        logic suffix_nz;
        rel = '0;
        rel.below_or_equal = 1'b1;
        rel.above_or_equal = 1'b1;
        suffix_nz = 1'b0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (flags[i].gt)
                rel.below_or_equal = 1'b0;
            if (flags[i].lt)
                rel.above_or_equal = 1'b0;
            // lowest differing lane wins
            if (flags[i].gt || flags[i].lt)
                rel.lex_less = flags[i].lt;
            suffix_nz = suffix_nz | flags[i].nz;
            if (suffix_nz && !flags[i].lt)
                rel.meets_below = 1'b1;
        end
    end

endmodule

[hw/rtl/vector_clock_unit.sv]
// vector clock unit top level: stored clock, parallel lanes, merge and output register
// depends on vcu_pkg, vcu_lane, vcu_merge
//
// usage:
//   s_* channel takes one item per cycle while s_tready is high: a command,
//   set-entry index and value, and a whole operand clock of eight 31-bit entries.
//   m_* channel returns one item per input item: the stored clock after the
//   command and four relation flags taken against the clock before it.
//   all lanes compare and update in the accept cycle, so the stored clock is
//   ready for the next item in the very next cycle.
//   result: m_tvalid rises in the cycle after the input is accepted.
//   throughput: one item per cycle while m_tready keeps the output register drained.
//   stall: the output register holds a result until m_tready; s_tready is high
//   whenever that register is empty or being drained in the same cycle.
//   reset: rst_n clears the stored clock to all zeros and empties the output.
//   lanes at or beyond THREADS ignore their operand and read zero.
module vector_clock_unit
    import vcu_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // command, entry_index, entry_value, operand_0 .. operand_7, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // clock_0 .. clock_7, below_or_equal, above_or_equal, lex_less,
    // meets_below, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    logic             in_fire;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;

    lane_flags_t      flags [LANES];
    logic [VAL_W-1:0] lane_next [LANES];
    relation_t        rel;

    logic             m_valid_reg;
    logic [VAL_W-1:0] out_clock_reg [LANES];
    relation_t        out_rel_reg;

    assign s_tready    = !m_valid_reg || m_tready;
    assign in_fire     = s_tvalid && s_tready;
    assign cmd         = s_tdata[CMD_LSB +: CMD_W];
    assign entry_index = s_tdata[IDX_LSB +: IDX_W];
    assign entry_value = s_tdata[VAL_LSB +: VAL_W];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < THREADS)
        begin : g_used
            localparam logic [IDX_W-1:0] LaneIdx = IDX_W'(i);
            logic [VAL_W-1:0] clock_reg;
            logic [VAL_W-1:0] clock_next;

            vcu_lane u_lane (
                .cmd         (cmd),
                .set_hit     (entry_index == LaneIdx),
                .entry_value (entry_value),
                .own         (clock_reg),
                .opnd        (s_tdata[OPND_LSB + i * VAL_W +: VAL_W]),
                .next_value  (clock_next),
                .flags       (flags[i])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    clock_reg <= '0;
                else if (in_fire)
                    clock_reg <= clock_next;
            end

            assign lane_next[i] = clock_next;
        end
        else
        begin : g_unused
            assign flags[i]     = '0;
            assign lane_next[i] = '0;
        end
    end

    vcu_merge u_merge (
        .flags (flags),
        .rel   (rel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_tready)
            m_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_clock_reg <= lane_next;
            out_rel_reg   <= rel;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < LANES; i++)
            m_tdata[i * VAL_W +: VAL_W] = out_clock_reg[i];
        m_tdata[FLAG_LSB +: FLAG_W] = out_rel_reg;
    end

endmodule

[hw/rtl/vcu_checker.sv]
// port-level checker for the vector clock unit, bound to the top level
// depends on vcu_pkg and vector_clock_unit_macros.svh
`include "vector_clock_unit_macros.svh"

module vcu_checker
    import vcu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic s_fire;
    logic s_load;
    logic m_equal;

    assign s_fire  = s_tvalid && s_tready;
    assign s_load  = s_fire && (s_tdata[CMD_LSB +: CMD_W] == CMD_LOAD);
    assign m_equal = m_tdata[FLAG_LSB] && m_tdata[FLAG_LSB + 1];

    // stalled result holds
    `VCU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // empty output register never blocks input
    `VCU_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_tvalid,
        s_tready, "input blocked with empty output")

    // load returns operand entry 0 as stored clock entry 0
    `VCU_ASSERT_NEXT(a_load_result, clk, rst_n, s_load,
        m_tvalid && (m_tdata[0 +: VAL_W] == $past(s_tdata[OPND_LSB +: VAL_W])),
        "load did not return operand entry 0")

    // equal clocks are never lexicographically less
    `VCU_ASSERT_SAME(a_equal_not_less, clk, rst_n, m_tvalid && m_equal,
        !m_tdata[FLAG_LSB + 2], "lex_less set on equal clocks")

endmodule

bind vector_clock_unit vcu_checker u_vcu_checker (.*);
